FILE: hdl/first_unique_letter_stream_macros.svh
// Assertion macros for the first unique letter stream block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef FIRST_UNIQUE_LETTER_STREAM_MACROS_SVH
`define FIRST_UNIQUE_LETTER_STREAM_MACROS_SVH

// same-cycle implication, checked outside reset
`define FULS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FULS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fuls_pkg.sv
// Shared constants and controller/datapath interface types.
// No dependencies.
`default_nettype none

package fuls_pkg;

  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int LETTER_W          = 5;
  localparam int CNT_W             = 2;

  localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_MANY = 2'd2;

  typedef struct packed {
    logic accept;
    logic update;
    logic advance;
    logic look;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic rep;
    logic next_end;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hdl/fuls_ctrl.sv
// Sequencer for the first unique letter stream block.
// Depends on fuls_pkg; drives the datapath command word.
`default_nettype none

module fuls_ctrl
  import fuls_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_LOOK = 5'b00100,
    S_EVAL = 5'b01000,
    S_RES  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        if (sts.skip) begin
          cmd.advance = 1'b1;
        end
        if (sts.skip && !sts.next_end) begin
          state_nxt = S_LOOK;
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.rep) begin
          cmd.advance = 1'b1;
        end
        if (sts.rep && !sts.next_end) begin
          state_nxt = S_LOOK;
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fuls_dp.sv
// Datapath: letter counts, arrival list, head pointer and result register.
// Depends on fuls_pkg; commanded by fuls_ctrl.
`default_nettype none

module fuls_dp
  import fuls_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [LETTER_W-1:0] in_letter,
  input  wire logic                in_string_start,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [LETTER_W-1:0]      out_unique_letter,
  input  wire dp_cmd_t             cmd,
  output dp_sts_t                  sts
);

  localparam int AW   = $clog2(ALPHABET_SIZE);
  localparam int IDXW = $clog2(ALPHABET_SIZE + 1);

  logic [CNT_W-1:0]    cnt_mem [ALPHABET_SIZE];
  logic [LETTER_W-1:0] ord_mem [ALPHABET_SIZE];

  logic [ALPHABET_SIZE-1:0] valid_r;
  logic [LETTER_W-1:0]      letter_r;
  logic                     in_range_r;
  logic [CNT_W-1:0]         cnt_rd_r;
  logic                     cnt_vld_r;
  logic [LETTER_W-1:0]      ord_rd_r;
  logic [IDXW-1:0]          head_r, head_nxt;
  logic [IDXW-1:0]          len_r, len_nxt;
  logic [LETTER_W-1:0]      head_letter_r, head_letter_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r;
  logic [LETTER_W-1:0]      out_letter_r;

  logic [AW-1:0]       letter_idx;
  logic [AW-1:0]       cnt_raddr;
  logic [IDXW-1:0]     head_inc;
  logic [CNT_W-1:0]    cnt_old;
  logic [CNT_W-1:0]    cnt_new;
  logic                append;
  logic                clear;
  logic                res_found;
  logic [LETTER_W-1:0] res_letter;

  assign letter_idx = AW'(letter_r);
  assign cnt_raddr  = cmd.look ? AW'(ord_rd_r) : AW'(in_letter);
  assign head_inc   = head_r + IDXW'(1);
  assign clear      = cmd.accept && in_string_start;
  assign cnt_old    = cnt_vld_r ? cnt_rd_r : CNT_ZERO;
  assign cnt_new    = (cnt_old == CNT_ZERO) ? CNT_ONE : CNT_MANY;
  assign append     = in_range_r && (cnt_old == CNT_ZERO) && (int'(len_r) < ALPHABET_SIZE);

  assign sts.skip     = in_range_r && (cnt_old != CNT_ZERO) && (head_r < len_r)
                        && (letter_r == head_letter_r);
  assign sts.rep      = cnt_vld_r && (cnt_rd_r == CNT_MANY);
  assign sts.next_end = (head_inc >= len_r);
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    head_nxt        = head_r;
    len_nxt         = len_r;
    head_letter_nxt = head_letter_r;
    if (clear) begin
      head_nxt = '0;
      len_nxt  = '0;
    end
    if (cmd.update && append) begin
      len_nxt = len_r + IDXW'(1);
      if (head_r == len_r) begin
        head_letter_nxt = letter_r;
      end
    end
    if (cmd.advance) begin
      head_nxt = head_inc;
    end
    if (cmd.look) begin
      head_letter_nxt = ord_rd_r;
    end
  end

  assign res_found  = (head_nxt < len_nxt);
  assign res_letter = res_found ? head_letter_nxt : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clear) begin
      valid_r <= '0;
    end else if (cmd.update && in_range_r) begin
      valid_r[letter_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    head_letter_r <= head_letter_nxt;
    if (cmd.accept) begin
      letter_r   <= in_letter;
      in_range_r <= (int'(in_letter) < ALPHABET_SIZE);
    end
    if (cmd.load_out) begin
      out_found_r  <= res_found;
      out_letter_r <= res_letter;
    end
  end

  // count store: write on update, read at the new letter or the head candidate
  always_ff @(posedge clk) begin
    if (cmd.update && in_range_r) begin
      cnt_mem[letter_idx] <= cnt_new;
    end
    if (cmd.accept || cmd.look) begin
      cnt_rd_r  <= cnt_mem[cnt_raddr];
      cnt_vld_r <= valid_r[cnt_raddr] && !clear;
    end
  end

  // arrival list: append at the tail, fetch the entry after the head
  always_ff @(posedge clk) begin
    if (cmd.update && append) begin
      ord_mem[len_r[AW-1:0]] <= letter_r;
    end
    if (cmd.advance) begin
      ord_rd_r <= ord_mem[head_inc[AW-1:0]];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_unique_letter = out_letter_r;

endmodule

`default_nettype wire

FILE: hdl/first_unique_letter_stream.sv
// First unique letter stream: top level joining sequencer and datapath.
// Depends on fuls_pkg, fuls_ctrl, fuls_dp and the assertion macro header.
//
// Usage:
//   Input word: in_letter (0 = a .. 25 = z) and in_string_start, which
//   clears the counts and the arrival list before its own letter. Letters
//   at or above the alphabet size change nothing but still yield a result.
//   Output word: out_found and out_unique_letter, the earliest letter of the
//   current string seen exactly once (0 when none), one word per input word.
//   Steps: with the head not moving and the result register free, the
//   result is loaded in the update step; each list entry the head
//   moves onto and must check adds a count read of that entry, then the check.
//   A new word is taken only once the last result is loaded; the head
//   moves at most ALPHABET_SIZE times per string.
//   Reset (rst_n low, synchronous) empties the counts and list and drops
//   out_valid. A stalled receiver holds the result register; one more input
//   word is taken meanwhile and its result waits until the register frees.
`default_nettype none

`include "first_unique_letter_stream_macros.svh"

module first_unique_letter_stream
  import fuls_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [LETTER_W-1:0] in_letter,
  input  wire logic                in_string_start,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_found,
  output logic [LETTER_W-1:0]      out_unique_letter
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fuls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  fuls_dp #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_letter         (in_letter),
    .in_string_start   (in_string_start),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_unique_letter (out_unique_letter),
    .cmd               (cmd),
    .sts               (sts)
  );

  `FULS_ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready, "accept while busy")
  `FULS_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0({cmd.accept, cmd.update, cmd.look}), "commands overlap")
  `FULS_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid, "loaded result not shown")
  `FULS_ASSERT_NOW(a_none_is_zero, out_valid && !out_found, out_unique_letter == '0, "letter set without found")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for first_unique_letter_stream: directed strings,
// random strings with idle gaps on both sides, and a long receiver hold-off.
// Depends on fuls_pkg and the first_unique_letter_stream top level.
`default_nettype none

module tb;
  import fuls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * ALPHABET_SIZE_DEF + 16;
  localparam int RANDOM_LETTERS = 290;

  typedef struct packed {
    logic                found;
    logic [LETTER_W-1:0] letter;
  } unique_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [LETTER_W-1:0] in_letter;
  logic                in_string_start;
  logic                out_valid;
  logic                out_ready;
  logic                out_found;
  logic [LETTER_W-1:0] out_unique_letter;

  first_unique_letter_stream dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_letter         (in_letter),
    .in_string_start   (in_string_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_unique_letter (out_unique_letter)
  );

  // shadow copy of the letter store
  logic [CNT_W-1:0]    seen_count [ALPHABET_SIZE_DEF];
  logic [LETTER_W-1:0] first_seen [ALPHABET_SIZE_DEF];
  logic [LETTER_W-1:0] seen_head;
  logic [LETTER_W-1:0] seen_length;

  unique_result_t expected_uniques[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  rx_stall_left = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  hold_on = 1'b0;
  event hold_off_ev;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_letters();
    for (int i = 0; i < ALPHABET_SIZE_DEF; i++) begin
      seen_count[i] = CNT_ZERO;
      first_seen[i] = '0;
    end
    seen_head = '0;
    seen_length = '0;
  endfunction

  function automatic unique_result_t track_letter(logic [LETTER_W-1:0] letter, logic start);
    unique_result_t res;
    if (start) clear_letters();
    if (letter < ALPHABET_SIZE_DEF) begin
      if (seen_count[letter] == CNT_ZERO) begin
        if (seen_length < ALPHABET_SIZE_DEF) begin
          first_seen[seen_length] = letter;
          seen_length = seen_length + 1'b1;
        end
        seen_count[letter] = CNT_ONE;
      end else begin
        seen_count[letter] = CNT_MANY;
      end
    end
    while (seen_head < seen_length && seen_count[first_seen[seen_head]] == CNT_MANY)
      seen_head = seen_head + 1'b1;
    res.found = seen_head < seen_length;
    res.letter = res.found ? first_seen[seen_head] : '0;
    return res;
  endfunction

  // enter and leave at a falling edge
  task automatic send_word(input logic [LETTER_W-1:0] letter, input logic start);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_letter <= letter;
    in_string_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_uniques.push_back(track_letter(letter, start));
    @(negedge clk);
  endtask

  task automatic flag_mismatch(input string what, input unique_result_t exp_r,
                               input unique_result_t got_r);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s): expected found=%0b letter=%0d, got found=%0b letter=%0d",
               what, exp_r.found, exp_r.letter, got_r.found, got_r.letter);
  endtask

  always @(posedge clk) begin
    unique_result_t got_r;
    unique_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      got_r.found = out_found;
      got_r.letter = out_unique_letter;
      if (expected_uniques.size() == 0) begin
        flag_mismatch("no word expected", '0, got_r);
      end else begin
        exp_r = expected_uniques.pop_front();
        if (got_r.found !== exp_r.found) flag_mismatch("found", exp_r, got_r);
        else if (got_r.letter !== exp_r.letter) flag_mismatch("unique_letter", exp_r, got_r);
      end
    end
  end

  always @(negedge clk) begin
    int gap;
    if (hold_on) begin
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_burst) begin
      out_ready <= 1'b1;
    end else begin
      gap = pick_gap();
      out_ready <= (gap == 0);
      rx_stall_left <= (gap == 0) ? 0 : gap - 1;
    end
  end

  initial forever begin
    @(hold_off_ev);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(5'd0, 1'b1);
    send_word(5'd1, 1'b0);
    send_word(5'd0, 1'b0);
    send_word(5'd1, 1'b0);
    send_word(5'd25, 1'b0);
    send_word(5'd25, 1'b0);
    send_word(5'd25, 1'b0);
    send_word(5'd26, 1'b0);
    send_word(5'd31, 1'b0);
    send_word(5'd2, 1'b0);
    send_word(5'd31, 1'b1);
    send_word(5'd24, 1'b0);
    send_word(5'd0, 1'b1);
    send_word(5'd25, 1'b0);
    send_word(5'd25, 1'b1);
    send_word(5'd1, 1'b0);
    send_word(5'd2, 1'b0);
    send_word(5'd25, 1'b0);
    send_word(5'd1, 1'b0);
    send_word(5'd30, 1'b0);
    send_word(5'd2, 1'b0);
    send_word(5'd21, 1'b0);
    send_word(5'd10, 1'b1);
    send_word(5'd10, 1'b0);
  endtask

  task automatic test_full_alphabet();
    tx_burst = 1'b1;
    rx_burst <= 1'b1;
    for (int i = 0; i < ALPHABET_SIZE_DEF; i++) send_word(i[LETTER_W-1:0], i == 0);
    for (int i = 0; i < ALPHABET_SIZE_DEF; i++) send_word(i[LETTER_W-1:0], 1'b0);
    tx_burst = 1'b0;
    rx_burst <= 1'b0;
    for (int i = ALPHABET_SIZE_DEF - 1; i >= 0; i--)
      send_word(i[LETTER_W-1:0], i == ALPHABET_SIZE_DEF - 1);
    for (int i = 0; i < ALPHABET_SIZE_DEF - 1; i++) send_word(i[LETTER_W-1:0], 1'b0);
  endtask

  task automatic test_random_strings();
    int taken;
    int len;
    int lo;
    int hi;
    int roll;
    logic [LETTER_W-1:0] letter;
    taken = 0;
    while (taken < RANDOM_LETTERS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      lo = $urandom_range(0, ALPHABET_SIZE_DEF - 1);
      hi = lo + $urandom_range(0, ALPHABET_SIZE_DEF - 1);
      if (hi > ALPHABET_SIZE_DEF - 1) hi = ALPHABET_SIZE_DEF - 1;
      tx_burst = ($urandom_range(0, 5) == 0);
      rx_burst <= ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) letter = LETTER_W'($urandom_range(ALPHABET_SIZE_DEF, 31));
        else if (roll < 10) letter = LETTER_W'($urandom_range(0, 31));
        else letter = LETTER_W'($urandom_range(lo, hi));
        send_word(letter, i == 0 || $urandom_range(0, 49) == 0);
        if (letter < ALPHABET_SIZE_DEF) taken++;
      end
    end
    tx_burst = 1'b0;
    rx_burst <= 1'b0;
  endtask

  task automatic test_receiver_hold();
    -> hold_off_ev;
    tx_burst = 1'b1;
    for (int i = 0; i < 40; i++)
      send_word(LETTER_W'($urandom_range(0, 7)), i == 0);
    tx_burst = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_letter = '0;
    in_string_start = 1'b0;
    out_ready = 1'b0;
    clear_letters();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_alphabet();
    test_receiver_hold();
    test_random_strings();
    test_receiver_hold();

    in_valid <= 1'b0;
    while (expected_uniques.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_uniques.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
